>>> rtl/hsl_pkg.sv
// Shared constants and types for the RGB to HSL converter.
package hsl_pkg;

    localparam int CHANNEL_BITS_DEF = 8;
    localparam int HUE_BITS_DEF     = 16;
    localparam int SAT_BITS         = 16;

    typedef enum logic [1:0] {
        MAX_RED,
        MAX_GREEN,
        MAX_BLUE
    } max_sel_t;

endpackage

>>> rtl/hsl_front.sv
// Two-stage front end: channel max/min, hue numerator and both division operands.
module hsl_front #(
    parameter int CHANNEL_BITS = 8,
    parameter int HUE_BITS     = 16,
    parameter int QUOT_BITS    = 16
) (
    input  logic                             aclk,
    input  logic                             en,
    input  logic [CHANNEL_BITS-1:0]          red,
    input  logic [CHANNEL_BITS-1:0]          green,
    input  logic [CHANNEL_BITS-1:0]          blue,
    output logic [CHANNEL_BITS+3+QUOT_BITS-1:0] hue_dvd,
    output logic [CHANNEL_BITS+3-1:0]        hue_dvs,
    output logic [CHANNEL_BITS+QUOT_BITS-1:0] sat_dvd,
    output logic [CHANNEL_BITS-1:0]          sat_dvs,
    output logic [CHANNEL_BITS:0]            lsum
);
    import hsl_pkg::*;

    localparam int CB  = CHANNEL_BITS;
    localparam int NW  = CB + 3;
    localparam int HDW = NW + QUOT_BITS;
    localparam int SDW = CB + QUOT_BITS;
    localparam logic [CB:0] FULL     = {1'b0, {CB{1'b1}}};
    localparam logic [CB:0] TWO_FULL = {{CB{1'b1}}, 1'b0};

    // stage 1
    logic [CB-1:0] r_reg, g_reg, b_reg, mx_reg, mn_reg;
    logic [CB-1:0] mx_next, mn_next;
    max_sel_t      sel_reg, sel_next;

    always_comb begin
        if (red >= green && red >= blue) begin
            sel_next = MAX_RED;
            mx_next  = red;
        end else if (green >= blue) begin
            sel_next = MAX_GREEN;
            mx_next  = green;
        end else begin
            sel_next = MAX_BLUE;
            mx_next  = blue;
        end
        mn_next = red;
        if (green < mn_next) mn_next = green;
        if (blue < mn_next)  mn_next = blue;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg   <= red;
            g_reg   <= green;
            b_reg   <= blue;
            mx_reg  <= mx_next;
            mn_reg  <= mn_next;
            sel_reg <= sel_next;
        end
    end

    // stage 2
    logic [CB-1:0]  d;
    logic [CB:0]    sum;
    logic [NW-1:0]  d_x, r_x, g_x, b_x, d6, num;
    logic [CB:0]    den_w;
    logic [HDW-1:0] hue_dvd_next;
    logic [NW-1:0]  hue_dvs_next;
    logic [SDW-1:0] sat_dvd_next, d_s;
    logic [CB-1:0]  sat_dvs_next;

    always_comb begin
        d   = mx_reg - mn_reg;
        sum = {1'b0, mx_reg} + {1'b0, mn_reg};
        d_x = NW'(d);
        r_x = NW'(r_reg);
        g_x = NW'(g_reg);
        b_x = NW'(b_reg);
        d6  = (d_x << 2) + (d_x << 1);
        case (sel_reg)
            MAX_RED:   num = (g_reg < b_reg) ? (d6 - (b_x - g_x)) : (g_x - b_x);
            MAX_GREEN: num = (d_x << 1) + b_x - r_x;
            MAX_BLUE:  num = (d_x << 2) + r_x - g_x;
            default:   num = '0;
        endcase
        den_w = (sum > FULL) ? (TWO_FULL - sum) : sum;
        d_s   = SDW'(d);
        if (d == '0) begin
            hue_dvd_next = '0;
            hue_dvs_next = NW'(1);
            sat_dvd_next = '0;
            sat_dvs_next = CB'(1);
        end else begin
            hue_dvd_next = HDW'(num) << HUE_BITS;
            hue_dvs_next = d6;
            sat_dvd_next = (d_s << SAT_BITS) - d_s;
            sat_dvs_next = den_w[CB-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hue_dvd <= hue_dvd_next;
            hue_dvs <= hue_dvs_next;
            sat_dvd <= sat_dvd_next;
            sat_dvs <= sat_dvs_next;
            lsum    <= sum;
        end
    end

endmodule

>>> rtl/hsl_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
module hsl_div #(
    parameter int DIVW = 11,
    parameter int QW   = 16
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [DIVW+QW-1:0]   dividend,
    input  logic [DIVW-1:0]      divisor,
    output logic [QW-1:0]        quotient
);
    import hsl_pkg::*;

    logic [DIVW-1:0] stg_rem [0:QW-1];
    logic [QW-1:0]   stg_lq  [0:QW];
    logic [DIVW-1:0] stg_dvs [0:QW-1];

    assign stg_rem[0] = dividend[DIVW+QW-1:QW];
    assign stg_lq[0]  = dividend[QW-1:0];
    assign stg_dvs[0] = divisor;

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DIVW:0]   trial;
        logic [QW-1:0]   lq_next;
        logic            fits;
        logic [QW-1:0]   lq_reg;

        always_comb begin
            trial   = {stg_rem[k], stg_lq[k][QW-1]};
            fits    = (trial >= {1'b0, stg_dvs[k]});
            lq_next = {stg_lq[k][QW-2:0], fits};
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                lq_reg <= lq_next;
            end
        end

        assign stg_lq[k+1] = lq_reg;

        // remainder and divisor are only carried to stages that still need them
        if (k < QW-1) begin : g_carry
            logic [DIVW-1:0] rem_next;
            logic [DIVW-1:0] rem_reg;
            logic [DIVW-1:0] dvs_reg;

            assign rem_next = fits ? DIVW'(trial - {1'b0, stg_dvs[k]}) : trial[DIVW-1:0];

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg <= rem_next;
                    dvs_reg <= stg_dvs[k];
                end
            end

            assign stg_rem[k+1] = rem_reg;
            assign stg_dvs[k+1] = dvs_reg;
        end
    end

    assign quotient = stg_lq[QW];

endmodule

>>> rtl/rgb_to_hsl_converter_top.sv
// Top level of the pipelined RGB to HSL converter.
//
// Input stream: one RGB pixel per transaction on s_tdata (red, green, blue
// from the lowest bit up). Output stream: one HSL result per transaction on
// m_tdata (hue, saturation, lightness sum from the lowest bit up).
// The pipeline has two front-end stages for max/min and the division
// operands, then one stage per quotient bit in the two dividers, which run
// side by side. Throughput is one pixel per cycle unless the receiver
// stalls; while it does not, a new transaction may enter every clock.
// The whole pipeline moves as one: it advances whenever the output register
// is empty or is being taken, so a receiver stall holds every stage in place
// and s_tready drops in the same cycle. Nothing is lost or repeated.
// Grey pixels give hue 0, saturation 0 and a lightness sum of twice the max.
// Reset (aresetn low, synchronous) empties the pipeline by clearing all
// valid bits; data registers are not reset.
module rgb_to_hsl_converter_top #(
    parameter int CHANNEL_BITS = hsl_pkg::CHANNEL_BITS_DEF,
    parameter int HUE_BITS     = hsl_pkg::HUE_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // red, green, blue
    input  logic [((3*CHANNEL_BITS+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // hue, saturation, lightness_sum
    output logic [((HUE_BITS+hsl_pkg::SAT_BITS+CHANNEL_BITS+1+7)/8)*8-1:0] m_tdata
);
    import hsl_pkg::*;

    localparam int CB    = CHANNEL_BITS;
    localparam int QW    = (HUE_BITS > SAT_BITS) ? HUE_BITS : SAT_BITS;
    localparam int LAT   = 2 + QW;
    localparam int OUTW  = HUE_BITS + SAT_BITS + CB + 1;
    localparam int OTDW  = ((OUTW + 7) / 8) * 8;

    logic            adv;
    logic [LAT-1:0]  valid_reg, valid_next;

    logic [CB-1:0]   red, green, blue;
    logic [CB+3+QW-1:0] hue_dvd;
    logic [CB+3-1:0] hue_dvs;
    logic [CB+QW-1:0] sat_dvd;
    logic [CB-1:0]   sat_dvs;
    logic [CB:0]     lsum;
    logic [CB:0]     lsum_reg [1:QW];
    logic [QW-1:0]   hue_q, sat_q;

    logic [HUE_BITS-1:0] hue;
    logic [SAT_BITS-1:0] saturation;
    logic [CB:0]         lightness_sum;

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;
    assign m_tvalid = valid_reg[LAT-1];

    assign red   = s_tdata[CB-1:0];
    assign green = s_tdata[2*CB-1:CB];
    assign blue  = s_tdata[3*CB-1:2*CB];

    assign valid_next = {valid_reg[LAT-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= valid_next;
        end
    end

    hsl_front #(
        .CHANNEL_BITS (CHANNEL_BITS),
        .HUE_BITS     (HUE_BITS),
        .QUOT_BITS    (QW)
    ) u_front (
        .aclk    (aclk),
        .en      (adv),
        .red     (red),
        .green   (green),
        .blue    (blue),
        .hue_dvd (hue_dvd),
        .hue_dvs (hue_dvs),
        .sat_dvd (sat_dvd),
        .sat_dvs (sat_dvs),
        .lsum    (lsum)
    );

    hsl_div #(
        .DIVW (CB + 3),
        .QW   (QW)
    ) u_hue_div (
        .aclk     (aclk),
        .en       (adv),
        .dividend (hue_dvd),
        .divisor  (hue_dvs),
        .quotient (hue_q)
    );

    hsl_div #(
        .DIVW (CB),
        .QW   (QW)
    ) u_sat_div (
        .aclk     (aclk),
        .en       (adv),
        .dividend (sat_dvd),
        .divisor  (sat_dvs),
        .quotient (sat_q)
    );

    always_ff @(posedge aclk) begin
        if (adv) begin
            lsum_reg[1] <= lsum;
            for (int i = 2; i <= QW; i++) begin
                lsum_reg[i] <= lsum_reg[i-1];
            end
        end
    end

    assign hue           = hue_q[HUE_BITS-1:0];
    assign saturation    = sat_q[SAT_BITS-1:0];
    assign lightness_sum = lsum_reg[QW];
    assign m_tdata       = OTDW'({lightness_sum, saturation, hue});

    // black and white are grey: no hue, no saturation
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && lightness_sum == '0) |-> (hue == '0 && saturation == '0))
        else $error("black pixel with nonzero hue or saturation");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && lightness_sum == {{CB{1'b1}}, 1'b0}) |->
            (hue == '0 && saturation == '0))
        else $error("white pixel with nonzero hue or saturation");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((hue_q >> HUE_BITS) == '0))
        else $error("hue quotient overflowed its width");

    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid straight after reset");

endmodule

>>> tb/sv/rgb_to_hsl_converter_top_tb.sv
// Self-checking testbench for the RGB to HSL converter: corner and random pixels under stalls.
`timescale 1ns / 100ps

module rgb_to_hsl_converter_top_tb;
    import hsl_pkg::*;

    typedef struct {
        logic [CHANNEL_BITS_DEF-1:0] red;
        logic [CHANNEL_BITS_DEF-1:0] green;
        logic [CHANNEL_BITS_DEF-1:0] blue;
        logic [HUE_BITS_DEF-1:0]     hue;
        logic [SAT_BITS-1:0]         saturation;
        logic [CHANNEL_BITS_DEF:0]   lightness_sum;
    } hsl_expect_t;

    class hsl_scoreboard;
        localparam logic [63:0] CH_FULL   = (64'd1 << CHANNEL_BITS_DEF) - 64'd1;
        localparam logic [63:0] SAT_SCALE = 64'd65535;

        hsl_expect_t pending[$];
        int pixels_noted;
        int results_checked;
        int failures;
        int grey_pixels;
        int sector_hits[3];

        function hsl_expect_t convert_pixel(logic [CHANNEL_BITS_DEF-1:0] r,
                                            logic [CHANNEL_BITS_DEF-1:0] g,
                                            logic [CHANNEL_BITS_DEF-1:0] b);
            hsl_expect_t res;
            max_sel_t    sel;
            logic [63:0] rr, gg, bb, hi, lo, d, sum, turn, den, sat;
            rr  = 64'(r);
            gg  = 64'(g);
            bb  = 64'(b);
            hi  = rr;
            lo  = rr;
            sel = MAX_RED;
            if (gg > hi) begin
                hi  = gg;
                sel = MAX_GREEN;
            end
            if (bb > hi) begin
                hi  = bb;
                sel = MAX_BLUE;
            end
            if (gg < lo) lo = gg;
            if (bb < lo) lo = bb;
            d   = hi - lo;
            sum = hi + lo;
            res.red           = r;
            res.green         = g;
            res.blue          = b;
            res.hue           = '0;
            res.saturation    = '0;
            res.lightness_sum = sum[CHANNEL_BITS_DEF:0];
            if (d == 0) begin
                grey_pixels++;
            end else begin
                sector_hits[sel]++;
                case (sel)
                    MAX_RED: begin
                        // wrap into one turn when green is below blue
                        if (gg < bb) turn = 64'd6 * d - (bb - gg);
                        else         turn = gg - bb;
                    end
                    MAX_GREEN: turn = (64'd2 * d + bb) - rr;
                    default:   turn = (64'd4 * d + rr) - gg;
                endcase
                turn = (turn << HUE_BITS_DEF) / (64'd6 * d);
                den  = (sum > CH_FULL) ? (64'd2 * CH_FULL - sum) : sum;
                sat  = (d * SAT_SCALE) / den;
                res.hue        = turn[HUE_BITS_DEF-1:0];
                res.saturation = sat[SAT_BITS-1:0];
            end
            return res;
        endfunction

        function void note_pixel(logic [CHANNEL_BITS_DEF-1:0] r,
                                 logic [CHANNEL_BITS_DEF-1:0] g,
                                 logic [CHANNEL_BITS_DEF-1:0] b);
            pending.push_back(convert_pixel(r, g, b));
            pixels_noted++;
        endfunction

        function void check_result(logic [47:0] data);
            hsl_expect_t exp_res;
            logic [HUE_BITS_DEF-1:0]   hue;
            logic [SAT_BITS-1:0]       sat;
            logic [CHANNEL_BITS_DEF:0] lsum;
            hue  = data[HUE_BITS_DEF-1:0];
            sat  = data[HUE_BITS_DEF +: SAT_BITS];
            lsum = data[HUE_BITS_DEF+SAT_BITS +: CHANNEL_BITS_DEF+1];
            results_checked++;
            if (pending.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result: hue %0d sat %0d lsum %0d", hue, sat, lsum);
                return;
            end
            exp_res = pending.pop_front();
            if (hue !== exp_res.hue || sat !== exp_res.saturation
                    || lsum !== exp_res.lightness_sum) begin
                failures++;
                if (failures <= 10)
                    $display("mismatch rgb (%0d,%0d,%0d): hue %0d/%0d sat %0d/%0d lsum %0d/%0d",
                             exp_res.red, exp_res.green, exp_res.blue,
                             exp_res.hue, hue, exp_res.saturation, sat,
                             exp_res.lightness_sum, lsum);
            end
        endfunction
    endclass

    localparam int LATENCY        = 2 + 16;
    localparam int HOLD_CYCLES    = 150;
    localparam int WATCHDOG_LIMIT = 3000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // red, green, blue
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;         // hue, saturation, lightness_sum

    hsl_scoreboard sb = new();

    int tx_idle_pct  = 22;
    int rx_idle_pct  = 65;
    bit hold_request = 1'b0;

    rgb_to_hsl_converter_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, g, r};
        do @(posedge aclk); while (!s_tready);
        sb.note_pixel(r, g, b);
    endtask

    function automatic logic [7:0] random_channel();
        case ($urandom_range(9))
            0:       return 8'd0;
            1:       return 8'hFF;
            2:       return 8'($urandom_range(3));
            3:       return 8'(255 - $urandom_range(3));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_random_pixels(int count);
        logic [7:0] r, g, b;
        repeat (count) begin
            r = random_channel();
            g = random_channel();
            b = random_channel();
            // ties between channels exercise the red, green, blue priority
            case ($urandom_range(19))
                0: g = r;
                1: b = g;
                2: b = r;
                3: begin
                    g = r;
                    b = r;
                end
                default: ;
            endcase
            send_pixel(r, g, b);
        end
    endtask

    initial begin : result_sink
        int hold_left;
        bit hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            if (hold_request && !hold_taken) begin
                hold_left  = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("watchdog: %0d cycles without a transaction", quiet);
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // corners: black, white, greys, primaries, hue wrap, ties, sum boundary
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd255, 8'd0,   8'd1);
        send_pixel(8'd255, 8'd10,  8'd0);
        send_pixel(8'd200, 8'd50,  8'd100);
        send_pixel(8'd30,  8'd220, 8'd90);
        send_pixel(8'd10,  8'd60,  8'd240);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0,   8'd255, 8'd255);
        send_pixel(8'd255, 8'd0,   8'd255);
        send_pixel(8'd255, 8'd1,   8'd0);
        send_pixel(8'd128, 8'd127, 8'd127);
        send_pixel(8'd128, 8'd128, 8'd127);
        send_pixel(8'd1,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd254, 8'd255);
        send_pixel(8'd254, 8'd255, 8'd254);
        send_pixel(8'd85,  8'd170, 8'd255);
        send_pixel(8'd170, 8'd85,  8'd0);

        send_random_pixels(700);

        tx_idle_pct = 65;
        rx_idle_pct = 22;
        send_random_pixels(700);

        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        hold_request = 1'b1;
        send_random_pixels(500);
        s_tvalid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);

        $display("covered %0d pixels: %0d grey, %0d/%0d/%0d red/green/blue max",
                 sb.pixels_noted, sb.grey_pixels, sb.sector_hits[MAX_RED],
                 sb.sector_hits[MAX_GREEN], sb.sector_hits[MAX_BLUE]);
        $display("%0d results checked over three stall profiles and a %0d-cycle hold-off",
                 sb.results_checked, HOLD_CYCLES);
        if (sb.failures == 0 && sb.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d failures, %0d results missing", sb.failures, sb.pending.size());
            $display("status: fail");
        end
        $finish;
    end
endmodule
